/* sv/owdm_pkg.sv */
// Package with constants, tables and payload types of the omni wheel drive mixer.
package owdm_pkg;

   localparam int ANGLE_BITS   = 16;
   localparam int DUTY_FULL    = 255;
   localparam int CORDIC_STEPS = 28;
   localparam int Q14_BITS     = 14;
   localparam int QUO_W        = Q14_BITS + 1;
   localparam int SPD_W        = 20;
   localparam int VEC_W        = 32;
   localparam int ANG_W        = 33;
   localparam int NUM_W        = 17;
   localparam int RECIP_W      = 18;
   localparam int DIV_SHIFT    = 22;
   localparam int DUTY_W       = 8;

   // ceil(2^22 / 25); exact floor division by 25 for numerators below 2^17.
   localparam logic [RECIP_W-1:0] DIV25_RECIP = 18'd167773;

   localparam logic [1:0] DIR_OFF = 2'd0;
   localparam logic [1:0] DIR_FWD = 2'd1;
   localparam logic [1:0] DIR_REV = 2'd2;

   localparam logic KIND_TRANSLATE = 1'b0;
   localparam logic KIND_ROTATE    = 1'b1;

   localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005
   };

   typedef struct packed {
      logic               kind;
      logic signed [15:0] heading;
      logic signed [7:0]  speed_percent;
   } req_type;

   typedef struct packed {
      logic [1:0] wheel1_dir;
      logic [7:0] wheel1_duty;
      logic [1:0] wheel2_dir;
      logic [7:0] wheel2_duty;
      logic [1:0] wheel3_dir;
      logic [7:0] wheel3_duty;
      logic [1:0] wheel4_dir;
      logic [7:0] wheel4_duty;
   } rsp_type;

   // Command data that rides along the rotation pipeline.
   typedef struct packed {
      logic             kind;
      logic             spd_neg;
      logic [SPD_W-1:0] spd_full;
      logic [1:0]       quad;
   } side_type;

endpackage

/* sv/owdm_if.sv */
// Handshake interfaces for the command and result channels.
interface owdm_req_if import owdm_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface owdm_rsp_if import owdm_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* sv/owdm_cordic.sv */
// Pipelined rotation-mode CORDIC, one micro-rotation per register stage.
module owdm_cordic import owdm_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic signed [ANG_W-1:0] in_z,
   input  side_type                in_side,
   output logic                    out_valid,
   output logic signed [VEC_W-1:0] out_x,
   output logic signed [VEC_W-1:0] out_y,
   output side_type                out_side
);

   logic signed [VEC_W-1:0] x_ff [CORDIC_STEPS];
   logic signed [VEC_W-1:0] y_ff [CORDIC_STEPS];
   logic signed [ANG_W-1:0] z_ff [CORDIC_STEPS];
   side_type                side_ff [CORDIC_STEPS];
   logic                    v_ff [CORDIC_STEPS];

   logic signed [VEC_W-1:0] xs [CORDIC_STEPS+1];
   logic signed [VEC_W-1:0] ys [CORDIC_STEPS+1];
   logic signed [ANG_W-1:0] zs [CORDIC_STEPS+1];
   side_type                ss [CORDIC_STEPS+1];
   logic                    vs [CORDIC_STEPS+1];

   always_comb begin
      xs[0] = VEC_W'(1) <<< 28;
      ys[0] = VEC_W'(1) <<< 28;
      zs[0] = in_z;
      ss[0] = in_side;
      vs[0] = in_valid;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         xs[i+1] = x_ff[i];
         ys[i+1] = y_ff[i];
         zs[i+1] = z_ff[i];
         ss[i+1] = side_ff[i];
         vs[i+1] = v_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            side_ff[i] <= ss[i];
            if (zs[i] >= 0) begin
               x_ff[i] <= xs[i] - (ys[i] >>> i);
               y_ff[i] <= ys[i] + (xs[i] >>> i);
               z_ff[i] <= zs[i] - signed'({1'b0, ATAN_TURN[i]});
            end else begin
               x_ff[i] <= xs[i] + (ys[i] >>> i);
               y_ff[i] <= ys[i] - (xs[i] >>> i);
               z_ff[i] <= zs[i] + signed'({1'b0, ATAN_TURN[i]});
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CORDIC_STEPS; i++) v_ff[i] <= 1'b0;
      end else if (en) begin
         for (int i = 0; i < CORDIC_STEPS; i++) v_ff[i] <= vs[i];
      end
   end

   assign out_valid = vs[CORDIC_STEPS];
   assign out_x     = xs[CORDIC_STEPS];
   assign out_y     = ys[CORDIC_STEPS];
   assign out_side  = ss[CORDIC_STEPS];

endmodule

/* sv/omni_wheel_drive_mixer.sv */
// Top level of the omni wheel drive mixer: heading and speed to four wheel commands.
//
//   channel    dir  payload                                 handshake
//   req_chan   in   kind, heading, speed_percent            valid/ready
//   rsp_chan   out  wheel1..4 dir and duty                  valid/ready
//
// One transaction enters per cycle while the result channel is not stalled; each result
// passes prep, 28 CORDIC stages, quadrant, 15 divider stages, scale, reciprocal and output.
// The latency is set by the CORDIC micro-rotations and the bit-per-stage divider.
// Reset clears the valid bits of all stages. While the result register holds an
// untaken transaction the whole pipeline holds and req_chan.ready is low.
module omni_wheel_drive_mixer import owdm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   owdm_req_if.sink    req_chan,
   owdm_rsp_if.source  rsp_chan
);

   localparam int DIV_ST = QUO_W;

   logic en;
   logic o_v_ff;
   rsp_type o_data_ff;

   assign en = !o_v_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   // Prep stage: phase shift by an eighth turn and speed magnitude.
   logic                    p_v_ff;
   logic signed [ANG_W-1:0] p_z_ff, p_z_in;
   side_type                p_side_ff, p_side_in;

   always_comb begin
      logic [31:0]           h32;
      logic [ANGLE_BITS-1:0] a;
      logic [31:0]           p;
      logic [7:0]            spd_abs;
      h32 = 32'(req_chan.data.heading);
      a = h32[ANGLE_BITS-1:0] - ANGLE_BITS'(1 << (ANGLE_BITS - 3));
      p = {a, {(32 - ANGLE_BITS){1'b0}}};
      p_z_in = signed'({3'b000, p[29:0]}) - ANG_W'(33'sh20000000);
      spd_abs = req_chan.data.speed_percent[7] ?
                8'(-req_chan.data.speed_percent) : 8'(req_chan.data.speed_percent);
      p_side_in.kind     = req_chan.data.kind;
      p_side_in.spd_neg  = req_chan.data.speed_percent[7];
      p_side_in.spd_full = SPD_W'(spd_abs) * SPD_W'(DUTY_FULL);
      p_side_in.quad     = p[31:30];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_z_ff    <= p_z_in;
         p_side_ff <= p_side_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) p_v_ff <= 1'b0;
      else if (en) p_v_ff <= req_chan.valid;
   end

   logic                    c_v;
   logic signed [VEC_W-1:0] c_x, c_y;
   side_type                c_side;

   owdm_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (p_v_ff),
      .in_z      (p_z_ff),
      .in_side   (p_side_ff),
      .out_valid (c_v),
      .out_x     (c_x),
      .out_y     (c_y),
      .out_side  (c_side)
   );

   // Stage 0 of these arrays is the quadrant stage, 1..DIV_ST the divider.
   logic             d_v_ff  [DIV_ST+1];
   logic [VEC_W-1:0] d_rx_ff [DIV_ST+1];
   logic [VEC_W-1:0] d_ry_ff [DIV_ST+1];
   logic [VEC_W-1:0] d_m_ff  [DIV_ST+1];
   logic [QUO_W-1:0] d_qx_ff [DIV_ST+1];
   logic [QUO_W-1:0] d_qy_ff [DIV_ST+1];
   logic             d_sx_ff [DIV_ST+1];
   logic             d_sy_ff [DIV_ST+1];
   side_type         d_side_ff [DIV_ST+1];

   logic [VEC_W-1:0] q_ax, q_ay, q_m;
   logic             q_sx, q_sy;

   always_comb begin
      logic signed [VEC_W-1:0] rx, ry;
      case (c_side.quad)
         2'd1: begin rx = -c_y; ry = c_x;  end
         2'd2: begin rx = -c_x; ry = -c_y; end
         2'd3: begin rx = c_y;  ry = -c_x; end
         default: begin rx = c_x; ry = c_y; end
      endcase
      q_sx = rx[VEC_W-1];
      q_sy = ry[VEC_W-1];
      q_ax = q_sx ? VEC_W'(-rx) : VEC_W'(rx);
      q_ay = q_sy ? VEC_W'(-ry) : VEC_W'(ry);
      q_m  = (q_ax > q_ay) ? q_ax : q_ay;
      if (q_m == '0) q_m = VEC_W'(1);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_rx_ff[0]   <= q_ax;
         d_ry_ff[0]   <= q_ay;
         d_m_ff[0]    <= q_m;
         d_qx_ff[0]   <= '0;
         d_qy_ff[0]   <= '0;
         d_sx_ff[0]   <= q_sx;
         d_sy_ff[0]   <= q_sy;
         d_side_ff[0] <= c_side;
         // Restoring division of |v| * 2^14 by m, one quotient bit per stage.
         for (int j = 1; j <= DIV_ST; j++) begin
            logic bx, by;
            bx = d_rx_ff[j-1] >= d_m_ff[j-1];
            by = d_ry_ff[j-1] >= d_m_ff[j-1];
            d_rx_ff[j]   <= (bx ? d_rx_ff[j-1] - d_m_ff[j-1] : d_rx_ff[j-1]) << 1;
            d_ry_ff[j]   <= (by ? d_ry_ff[j-1] - d_m_ff[j-1] : d_ry_ff[j-1]) << 1;
            d_qx_ff[j]   <= {d_qx_ff[j-1][QUO_W-2:0], bx};
            d_qy_ff[j]   <= {d_qy_ff[j-1][QUO_W-2:0], by};
            d_m_ff[j]    <= d_m_ff[j-1];
            d_sx_ff[j]   <= d_sx_ff[j-1];
            d_sy_ff[j]   <= d_sy_ff[j-1];
            d_side_ff[j] <= d_side_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= DIV_ST; j++) d_v_ff[j] <= 1'b0;
      end else if (en) begin
         d_v_ff[0] <= c_v;
         for (int j = 1; j <= DIV_ST; j++) d_v_ff[j] <= d_v_ff[j-1];
      end
   end

   // Scale stage: the denominator 100 * 2^14 is 25 * 2^16, so shift off 2^16 here.
   logic             s_v_ff;
   logic [NUM_W-1:0] s_nx_ff, s_ny_ff, s_nx_in, s_ny_in;
   logic             s_negx_ff, s_negy_ff, s_kind_ff;

   always_comb begin
      logic [QUO_W+SPD_W-1:0] px, py;
      side_type               sd;
      sd = d_side_ff[DIV_ST];
      px = (QUO_W+SPD_W)'(d_qx_ff[DIV_ST]) * (QUO_W+SPD_W)'(sd.spd_full);
      py = (QUO_W+SPD_W)'(d_qy_ff[DIV_ST]) * (QUO_W+SPD_W)'(sd.spd_full);
      if (sd.kind == KIND_ROTATE) begin
         s_nx_in = NUM_W'(sd.spd_full >> 2);
         s_ny_in = NUM_W'(sd.spd_full >> 2);
      end else begin
         s_nx_in = px[16 +: NUM_W];
         s_ny_in = py[16 +: NUM_W];
      end
   end

   // In rotate mode the sign comes from the speed alone, not from the vector.
   always_ff @(posedge clock) begin
      if (en) begin
         s_nx_ff   <= s_nx_in;
         s_ny_ff   <= s_ny_in;
         s_kind_ff <= d_side_ff[DIV_ST].kind;
         s_negx_ff <= d_side_ff[DIV_ST].spd_neg ^
                      (d_sx_ff[DIV_ST] && (d_side_ff[DIV_ST].kind == KIND_TRANSLATE));
         s_negy_ff <= d_side_ff[DIV_ST].spd_neg ^
                      (d_sy_ff[DIV_ST] && (d_side_ff[DIV_ST].kind == KIND_TRANSLATE));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s_v_ff <= 1'b0;
      else if (en) s_v_ff <= d_v_ff[DIV_ST];
   end

   // Reciprocal stage: floor division by 25.
   logic             r_v_ff;
   logic [NUM_W-1:0] r_vx_ff, r_vy_ff;
   logic             r_negx_ff, r_negy_ff, r_kind_ff;

   always_ff @(posedge clock) begin
      logic [NUM_W+RECIP_W-1:0] mx, my;
      mx = (NUM_W+RECIP_W)'(s_nx_ff) * (NUM_W+RECIP_W)'(DIV25_RECIP);
      my = (NUM_W+RECIP_W)'(s_ny_ff) * (NUM_W+RECIP_W)'(DIV25_RECIP);
      if (en) begin
         r_vx_ff   <= NUM_W'(mx >> DIV_SHIFT);
         r_vy_ff   <= NUM_W'(my >> DIV_SHIFT);
         r_negx_ff <= s_negx_ff;
         r_negy_ff <= s_negy_ff;
         r_kind_ff <= s_kind_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) r_v_ff <= 1'b0;
      else if (en) r_v_ff <= s_v_ff;
   end

   function automatic logic [DUTY_W-1:0] sat_duty(input logic [NUM_W-1:0] mag);
      logic [NUM_W-1:0] m;
      m = mag;
      if (m > NUM_W'(DUTY_FULL)) m = NUM_W'(DUTY_FULL);
      if (m > NUM_W'(255)) m = NUM_W'(255);
      return m[DUTY_W-1:0];
   endfunction

   function automatic logic [1:0] dir_code(input logic [NUM_W-1:0] mag, input logic neg);
      if (mag == '0) return DIR_OFF;
      return neg ? DIR_REV : DIR_FWD;
   endfunction

   rsp_type o_data_in;

   always_comb begin
      logic n1, n2, n3, n4;
      if (r_kind_ff == KIND_ROTATE) begin
         n1 = r_negx_ff;
         n2 = r_negx_ff;
         n3 = r_negx_ff;
         n4 = r_negx_ff;
      end else begin
         n1 = !r_negx_ff;
         n2 = !r_negy_ff;
         n3 = r_negx_ff;
         n4 = r_negy_ff;
      end
      o_data_in.wheel1_dir  = dir_code(r_vx_ff, n1);
      o_data_in.wheel1_duty = sat_duty(r_vx_ff);
      o_data_in.wheel2_dir  = dir_code(r_vy_ff, n2);
      o_data_in.wheel2_duty = sat_duty(r_vy_ff);
      o_data_in.wheel3_dir  = dir_code(r_vx_ff, n3);
      o_data_in.wheel3_duty = sat_duty(r_vx_ff);
      o_data_in.wheel4_dir  = dir_code(r_vy_ff, n4);
      o_data_in.wheel4_duty = sat_duty(r_vy_ff);
   end

   always_ff @(posedge clock) begin
      if (en) o_data_ff <= o_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) o_v_ff <= 1'b0;
      else if (en) o_v_ff <= r_v_ff;
   end

   assign rsp_chan.valid = o_v_ff;
   assign rsp_chan.data  = o_data_ff;

endmodule
